>>> rtl/core/fmr_pkg.sv
// Shared types and constants for the framed message receiver.
`timescale 1ns / 1ps

package fmr_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  localparam logic [2:0] ST_TEMP    = 3'd0;
  localparam logic [2:0] ST_HUM     = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_BADHDR  = 3'd3;
  localparam logic [2:0] ST_BADVER  = 3'd4;
  localparam logic [2:0] ST_BADADDR = 3'd5;
  localparam logic [2:0] ST_BADSUM  = 3'd6;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] HDR_BYTE0     = 8'h46;  // 'F'
  localparam logic [7:0] HDR_BYTE1     = 8'h48;  // 'H'
  localparam logic [7:0] TAG_TEMP      = 8'h01;
  localparam logic [7:0] TAG_HUM       = 8'h02;
  localparam int         HDR_LEN       = 5;
  localparam logic [2:0] SEEN_MAX      = 3'd7;
  localparam logic [7:0] WORD_BYTES    = 8'd4;

  localparam logic [7:0] REG_STATION = 8'd0;
  localparam logic [7:0] REG_VERSION = 8'd1;

  // m_tdata layout
  localparam int OUT_W = 112;
  localparam int ST_LO = 0;
  localparam int TAG_LO = 3;
  localparam int PAY_LO = 11;
  localparam int TMP_LO = 43;
  localparam int HUM_LO = 75;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [7:0]  tag;
    logic [31:0] payload;
    logic [31:0] temp;
    logic [31:0] hum;
  } fmr_result_t;

endpackage

>>> rtl/core/framed_message_receiver.sv
// Top level of the framed message receiver: input stage, parser, output stage.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  s       | in  | s_tvalid/s_tready | s_tdata: rx_byte; s_tuser: mode
//  m       | out | m_tvalid/m_tready | m_tdata: status, tag, payload, temp, hum
//  cfg     | in  | cfg_valid/ready   | cfg_index, cfg_data (0 address, 1 version)
//
// One beat per cycle sustained while m_tready is high; a beat is taken into the
// input register, parsed from there once the output stage can take a result and,
// for a checksum byte, its result is registered into m_tdata.
// rst is synchronous; it empties both stages and restarts the preamble hunt.
// A stalled m beat holds; the input register still takes one more s beat.
`timescale 1ns / 1ps

module framed_message_receiver #(
  parameter int PREAMBLE_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  logic         s_tuser,   // [0] mode
  output logic         m_tvalid,
  input  logic         m_tready,
  // [2:0] frame_status, [10:3] frame_tag, [42:11] payload_word,
  // [74:43] temperature_word, [106:75] humidity_word, [111:107] zero
  output logic [111:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import fmr_pkg::*;

  logic        in_valid;
  logic        in_mode;
  logic [7:0]  in_byte;
  logic        can_proc;
  logic        step;
  logic [7:0]  station_address;
  logic [7:0]  expected_version;
  fmr_result_t res;
  fmr_result_t out_res;

  assign can_proc  = !m_tvalid || m_tready;
  assign step      = in_valid && can_proc;
  assign s_tready  = !in_valid || can_proc;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address  <= 8'd1;
      expected_version <= 8'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STATION) begin
        station_address <= cfg_data;
      end
      if (cfg_index == REG_VERSION) begin
        expected_version <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  fmr_parser #(
    .PREAMBLE_COUNT(PREAMBLE_COUNT)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .mode             (in_mode),
    .rx_byte          (in_byte),
    .station_address  (station_address),
    .expected_version (expected_version),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_proc) begin
      m_tvalid <= res.valid;
    end
  end

  // res.valid already includes step
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'd0, out_res.hum, out_res.temp, out_res.payload,
                    out_res.tag, out_res.status};

endmodule

>>> rtl/core/fmr_parser.sv
// Frame parsing state, checksum and stored words; one item per step.
`timescale 1ns / 1ps

module fmr_parser #(
  parameter int PREAMBLE_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                mode,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          station_address,
  input  logic [7:0]          expected_version,
  output fmr_pkg::fmr_result_t res
);
  import fmr_pkg::*;

  localparam logic [2:0] PRE_THRESH = 3'(PREAMBLE_COUNT);
  localparam logic [2:0] HDR_LAST   = 3'(HDR_LEN);

  phase_t      phase, phase_next;
  logic [2:0]  preamble_seen, preamble_seen_next;
  logic [2:0]  header_index, header_index_next;
  logic [7:0]  header_store [HDR_LEN];
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [31:0] capture_word, capture_word_next;
  logic [31:0] temperature_store, temperature_store_next;
  logic [31:0] humidity_store, humidity_store_next;
  logic        hdr_write;
  logic        long_enough;
  logic [2:0]  verdict;

  assign long_enough = (payload_length >= WORD_BYTES);

  // Check order: header, version, address, checksum, then tag
  always_comb begin
    priority if (header_store[0] != HDR_BYTE0 || header_store[1] != HDR_BYTE1) begin
      verdict = ST_BADHDR;
    end else if (header_store[2] != expected_version) begin
      verdict = ST_BADVER;
    end else if (header_store[3] != station_address) begin
      verdict = ST_BADADDR;
    end else if (running_sum != rx_byte) begin
      verdict = ST_BADSUM;
    end else if (header_store[4] == TAG_TEMP && long_enough) begin
      verdict = ST_TEMP;
    end else if (header_store[4] == TAG_HUM && long_enough) begin
      verdict = ST_HUM;
    end else begin
      verdict = ST_OTHER;
    end
  end

  always_comb begin
    phase_next             = phase;
    preamble_seen_next     = preamble_seen;
    header_index_next      = header_index;
    payload_length_next    = payload_length;
    payload_index_next     = payload_index;
    running_sum_next       = running_sum;
    capture_word_next      = capture_word;
    temperature_store_next = temperature_store;
    humidity_store_next    = humidity_store;
    hdr_write              = 1'b0;
    res                    = '0;
    res.status             = verdict;
    res.tag                = header_store[4];
    res.payload            = capture_word;
    res.temp               = temperature_store;
    res.hum                = humidity_store;

    if (mode) begin
      phase_next          = PH_HUNT;
      preamble_seen_next  = '0;
      header_index_next   = '0;
      payload_length_next = '0;
      payload_index_next  = '0;
      running_sum_next    = '0;
      capture_word_next   = '0;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == PREAMBLE_BYTE && preamble_seen < SEEN_MAX) begin
            preamble_seen_next = preamble_seen + 3'd1;
          end
          if (preamble_seen_next >= PRE_THRESH) begin
            phase_next = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (header_index < HDR_LAST) begin
            hdr_write         = 1'b1;
            header_index_next = header_index + 3'd1;
          end
          running_sum_next = running_sum + rx_byte;
          if (header_index_next >= HDR_LAST) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          payload_length_next = rx_byte;
          running_sum_next    = running_sum + rx_byte;
          payload_index_next  = '0;
          phase_next          = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (payload_index < WORD_BYTES) begin
            capture_word_next = capture_word
                | ({24'd0, rx_byte} << {payload_index[1:0], 3'b000});
          end
          running_sum_next   = running_sum + rx_byte;
          payload_index_next = payload_index + 8'd1;
          if (payload_index_next >= payload_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res.valid = 1'b1;
          if (verdict == ST_TEMP) begin
            temperature_store_next = capture_word;
            res.temp               = capture_word;
          end
          if (verdict == ST_HUM) begin
            humidity_store_next = capture_word;
            res.hum             = capture_word;
          end
          phase_next          = PH_HUNT;
          preamble_seen_next  = '0;
          header_index_next   = '0;
          payload_length_next = '0;
          payload_index_next  = '0;
          running_sum_next    = '0;
          capture_word_next   = '0;
        end
        default: begin
          phase_next          = PH_HUNT;
          preamble_seen_next  = '0;
          header_index_next   = '0;
          payload_length_next = '0;
          payload_index_next  = '0;
          running_sum_next    = '0;
          capture_word_next   = '0;
        end
      endcase
    end
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      preamble_seen     <= '0;
      header_index      <= '0;
      payload_length    <= '0;
      payload_index     <= '0;
      running_sum       <= '0;
      capture_word      <= '0;
      temperature_store <= '0;
      humidity_store    <= '0;
    end else if (step) begin
      phase             <= phase_next;
      preamble_seen     <= preamble_seen_next;
      header_index      <= header_index_next;
      payload_length    <= payload_length_next;
      payload_index     <= payload_index_next;
      running_sum       <= running_sum_next;
      capture_word      <= capture_word_next;
      temperature_store <= temperature_store_next;
      humidity_store    <= humidity_store_next;
    end
  end

  // Header bytes hold no reset value; each is written before the check byte
  always_ff @(posedge clk) begin
    if (step && hdr_write) begin
      header_store[header_index] <= rx_byte;
    end
  end

endmodule

>>> rtl/core/fmr_checker.sv
// Port-level checks on the framed message receiver, bound to the top level.
`timescale 1ns / 1ps

module fmr_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);
  import fmr_pkg::*;

  logic [2:0]  status;
  logic [7:0]  tag;
  logic [31:0] payload;
  logic [31:0] temp;
  logic [31:0] hum;

  assign status  = m_tdata[ST_LO +: 3];
  assign tag     = m_tdata[TAG_LO +: 8];
  assign payload = m_tdata[PAY_LO +: 32];
  assign temp    = m_tdata[TMP_LO +: 32];
  assign hum     = m_tdata[HUM_LO +: 32];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status <= ST_BADSUM)
    else $error("frame status out of range");

  a_temp_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_TEMP |-> temp == payload && tag == TAG_TEMP)
    else $error("temperature frame did not store its payload");

  a_hum_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_HUM |-> hum == payload && tag == TAG_HUM)
    else $error("humidity frame did not store its payload");

endmodule

bind framed_message_receiver fmr_checker u_fmr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/framed_message_receiver_tb.sv
// Self-checking testbench for the framed message receiver: frame stimulus and scoreboard.
`timescale 1ns / 1ps

module framed_message_receiver_tb;
  import fmr_pkg::*;

  localparam int PREAMBLE_COUNT = 4;
  localparam int TAG_POS        = 4;  // tag is the last header byte
  localparam int BEAT_TARGET    = 1850;
  localparam int PAY_RANDOM     = 0;
  localparam int PAY_ZERO       = 1;
  localparam int PAY_ONES       = 2;
  localparam int NO_CUT         = -1;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  tag;
    logic [31:0] payload;
    logic [31:0] temp;
    logic [31:0] hum;
  } frame_report_t;

  class frame_scoreboard;
    logic [7:0]    station;
    logic [7:0]    version;
    phase_t        phase;
    logic [2:0]    seen;
    logic [2:0]    hdr_idx;
    logic [7:0]    hdr [HDR_LEN];
    logic [7:0]    pay_len;
    logic [7:0]    pay_idx;
    logic [7:0]    sum;
    logic [31:0]   capture;
    logic [31:0]   temp_word;
    logic [31:0]   hum_word;
    frame_report_t reports[$];
    int            errors;

    function new();
      station   = 8'd1;
      version   = 8'd1;
      temp_word = '0;
      hum_word  = '0;
      errors    = 0;
      foreach (hdr[i]) hdr[i] = '0;
      restart();
    endfunction

    function void restart();
      phase   = PH_HUNT;
      seen    = '0;
      hdr_idx = '0;
      pay_len = '0;
      pay_idx = '0;
      sum     = '0;
      capture = '0;
    endfunction

    function void set_register(logic [7:0] idx, logic [7:0] val);
      if (idx == REG_STATION) station = val;
      else if (idx == REG_VERSION) version = val;
    endfunction

    // First failing check wins; only good tag 1/2 frames with a full word update the stores.
    function logic [2:0] judge(logic [7:0] chk);
      logic long_enough;
      long_enough = pay_len >= WORD_BYTES;
      if (hdr[0] != HDR_BYTE0 || hdr[1] != HDR_BYTE1) return ST_BADHDR;
      if (hdr[2] != version) return ST_BADVER;
      if (hdr[3] != station) return ST_BADADDR;
      if (sum != chk) return ST_BADSUM;
      if (hdr[TAG_POS] == TAG_TEMP && long_enough) begin
        temp_word = capture;
        return ST_TEMP;
      end
      if (hdr[TAG_POS] == TAG_HUM && long_enough) begin
        hum_word = capture;
        return ST_HUM;
      end
      return ST_OTHER;
    endfunction

    function void note_beat(logic mode, logic [7:0] b);
      frame_report_t r;
      if (mode) begin
        restart();
        return;
      end
      case (phase)
        PH_HUNT: begin
          if (b == PREAMBLE_BYTE && seen < SEEN_MAX) seen++;
          if (seen >= PREAMBLE_COUNT) phase = PH_HEADER;
        end
        PH_HEADER: begin
          if (hdr_idx < HDR_LEN) begin
            hdr[hdr_idx] = b;
            hdr_idx++;
          end
          sum += b;
          if (hdr_idx >= HDR_LEN) phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          pay_len = b;
          sum += b;
          pay_idx = '0;
          phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pay_idx < WORD_BYTES) capture |= {24'd0, b} << (8 * pay_idx);
          sum += b;
          pay_idx++;
          if (pay_idx >= pay_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          r.status  = judge(b);
          r.tag     = hdr[TAG_POS];
          r.payload = capture;
          r.temp    = temp_word;
          r.hum     = hum_word;
          reports.push_back(r);
          restart();
        end
        default: restart();
      endcase
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      frame_report_t want;
      if (reports.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none actual %h", $time, d);
        return;
      end
      want = reports.pop_front();
      field_check("frame_status", 32'(want.status), 32'(d[ST_LO +: 3]));
      field_check("frame_tag", 32'(want.tag), 32'(d[TAG_LO +: 8]));
      field_check("payload_word", want.payload, d[PAY_LO +: 32]);
      field_check("temperature_word", want.temp, d[TMP_LO +: 32]);
      field_check("humidity_word", want.hum, d[HUM_LO +: 32]);
    endfunction
  endclass

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata   = '0;
  logic         s_tuser   = 1'b0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [111:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [7:0]   cfg_data  = '0;

  bit              calm = 1'b0;
  int              beats_sent = 0;
  frame_scoreboard sb;

  framed_message_receiver #(.PREAMBLE_COUNT(PREAMBLE_COUNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic send_beat(input logic mode, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 7) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(mode, b);
    beats_sent++;
  endtask

  // Hold off the sender until every report is out and the pipeline is empty.
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Preamble (with stray non-FF bytes), header, length, payload and checksum.
  // cut_at replaces the byte at that frame position with a line timeout.
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] addr,
                            input logic [7:0] tag, input logic [7:0] len,
                            input int pay_kind, input bit hdr_fault,
                            input logic [7:0] sum_delta, input int cut_at);
    logic [7:0] seq[$];
    logic [7:0] chk;
    logic [7:0] v;
    int         k;
    seq = {};
    seq.push_back(HDR_BYTE0);
    seq.push_back(HDR_BYTE1);
    seq.push_back(ver);
    seq.push_back(addr);
    seq.push_back(tag);
    seq.push_back(len);
    if (hdr_fault) begin
      k = $urandom_range(0, 1);
      seq[k] = seq[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < len; k++) begin
      case (pay_kind)
        PAY_ZERO: v = 8'h00;
        PAY_ONES: v = 8'hFF;
        default:  v = 8'($urandom);
      endcase
      seq.push_back(v);
    end
    chk = '0;
    foreach (seq[i]) chk += seq[i];
    seq.push_back(chk + sum_delta);
    for (k = 0; k < PREAMBLE_COUNT; k++) begin
      if ($urandom_range(0, 99) < 15) send_beat(1'b0, 8'($urandom_range(0, 254)));
      send_beat(1'b0, PREAMBLE_BYTE);
    end
    for (k = 0; k < seq.size(); k++) begin
      if (k == cut_at) begin
        send_beat(1'b1, 8'($urandom));
        break;
      end
      send_beat(1'b0, seq[k]);
    end
  endtask

  task automatic send_random_frame(input bit broken);
    logic [7:0] ver;
    logic [7:0] addr;
    logic [7:0] tag;
    logic [7:0] len;
    int         r;
    int         kind;
    ver  = ($urandom_range(0, 99) < 88) ? sb.version : 8'($urandom);
    addr = ($urandom_range(0, 99) < 88) ? sb.station : 8'($urandom);
    r = $urandom_range(0, 99);
    tag = (r < 40) ? TAG_TEMP : (r < 80) ? TAG_HUM : 8'($urandom);
    r = $urandom_range(0, 99);
    len = (r < 85) ? 8'($urandom_range(0, 8)) :
          (r < 97) ? 8'($urandom_range(9, 40)) : 8'($urandom_range(41, 255));
    r = $urandom_range(0, 99);
    kind = (r < 5) ? PAY_ZERO : (r < 10) ? PAY_ONES : PAY_RANDOM;
    send_frame(ver, addr, tag, len, kind, $urandom_range(0, 99) < 6,
               ($urandom_range(0, 99) < 90) ? 8'd0 : 8'($urandom_range(1, 255)),
               broken ? $urandom_range(0, 6 + len) : NO_CUT);
  endtask

  initial begin
    int frames;
    int r;
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset register values.
    send_frame(8'd1, 8'd1, TAG_TEMP, 8'd4, PAY_ONES, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd1, TAG_HUM, 8'd4, PAY_ZERO, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd1, TAG_TEMP, 8'd3, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd1, TAG_HUM, 8'd0, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd1, 8'hFF, 8'd5, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd1, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b1, 8'd0, NO_CUT);
    send_frame(8'd7, 8'd1, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd9, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'd1, TAG_HUM, 8'd6, PAY_RANDOM, 1'b0, 8'd1, NO_CUT);
    // Bad header and bad version together: header wins.
    send_frame(8'd7, 8'd9, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b1, 8'd3, NO_CUT);
    // Timeout mid-frame and during the hunt, then a clean frame.
    send_frame(8'd1, 8'd1, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b0, 8'd0, 7);
    send_beat(1'b0, PREAMBLE_BYTE);
    send_beat(1'b0, PREAMBLE_BYTE);
    send_beat(1'b1, 8'h00);
    send_frame(8'd1, 8'd1, TAG_TEMP, 8'd5, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    // Header-looking bytes without preamble after a frame end: ignored.
    send_beat(1'b0, HDR_BYTE0);
    send_beat(1'b0, HDR_BYTE1);
    send_beat(1'b1, 8'hFF);

    // Register extremes.
    settle_idle();
    write_register(REG_STATION, 8'h00);
    write_register(REG_VERSION, 8'hFF);
    send_frame(8'hFF, 8'h00, TAG_HUM, 8'd4, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'd1, 8'h00, TAG_HUM, 8'd4, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    settle_idle();
    write_register(REG_STATION, 8'hFF);
    write_register(REG_VERSION, 8'h00);
    send_frame(8'h00, 8'hFF, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);
    send_frame(8'h00, 8'h00, TAG_TEMP, 8'd4, PAY_RANDOM, 1'b0, 8'd0, NO_CUT);

    frames = 0;
    while (beats_sent < BEAT_TARGET) begin
      calm <= (beats_sent >= 700 && beats_sent < 1100);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Noise burst; the closing timeout puts the parser back in the hunt.
        n = $urandom_range(1, 6);
        repeat (n) send_beat($urandom_range(0, 3) == 0, 8'($urandom));
        send_beat(1'b1, 8'($urandom));
      end else begin
        send_random_frame(r < 14);
        frames++;
      end
      if (frames % 25 == 24) begin
        settle_idle();
        r = $urandom_range(0, 2);
        write_register(REG_STATION, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(0, 2);
          write_register(REG_VERSION, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
        end
        frames++;
      end
    end

    s_tvalid <= 1'b0;
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
